### rtl/jc_pkg.sv
// Shared types, constants and codes for the joystick conditioner.
package jc_pkg;

    localparam int RAW_W    = 12;
    localparam int VAL_W    = 10;
    localparam int BIAS_W   = 11;
    localparam int SUM_W    = 20;
    localparam int CNT_W    = 8;
    localparam int NUM_AXES = 4;

    // Number of calibration items averaged into each bias (a power of two).
    localparam int BIAS_SAMPLES = 16;

    localparam int SCALE_FULL = 1000;
    localparam int RAW_FULL   = 4095;
    localparam int TRIM_STEP  = 10;
    localparam int BIAS_LIMIT = 1000;

    localparam int AXIS_THROTTLE = 0;
    localparam int AXIS_ROLL     = 1;
    localparam int AXIS_PITCH    = 2;

    typedef logic [RAW_W-1:0]         raw_t;
    typedef logic [VAL_W-1:0]         val_t;
    typedef logic signed [BIAS_W-1:0] bias_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    typedef enum logic [2:0] {
        FUNC_SAMPLE   = 3'd0,
        FUNC_CAL      = 3'd1,
        FUNC_ROLL_UP  = 3'd2,
        FUNC_PITCH_DN = 3'd3,
        FUNC_ROLL_DN  = 3'd4,
        FUNC_PITCH_UP = 3'd5
    } func_t;

    typedef enum logic [2:0] {
        CFG_MIDPOINT          = 3'd0,
        CFG_CENTER_DEADZONE   = 3'd1,
        CFG_THROTTLE_DEADZONE = 3'd2,
        CFG_RANGE_LOW         = 3'd3,
        CFG_RANGE_HIGH        = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [9:0] midpoint;
        logic [8:0] center_deadzone;
        logic [9:0] throttle_deadzone;
        logic [9:0] range_low;
        logic [9:0] range_high;
    } cfg_t;

endpackage

### rtl/joystick_conditioner.sv
// Top level of the joystick conditioner: input stage, bias store, conditioning, output stage.
//
//  Channel   Direction  Handshake            Payload
//  s_*       in         s_tvalid / s_tready  tuser: func; tdata: four raw 12-bit readings
//  m_*       out        m_tvalid / m_tready  tdata: four conditioned 10-bit values
//  cfg_*     in         cfg_valid/cfg_ready  cfg_index: register index; cfg_data: value
//
// One item per cycle sustained while no sample item waits behind a stalled output.
// A sample item passes from the input register into the output register, from which
// it is offered on m_*. Calibration and trim items give no output item and take
// effect on the item that follows them. The throughput is set by the single pass
// from the input register through the conditioning logic into the output register.
// Reset restores the register defaults and clears all biases, sums and the
// calibration count. A stalled output holds its item while the input register
// still takes calibration and trim items; s_tready drops only when a sample item
// waits behind a stalled output. Configuration writes are always accepted.
module joystick_conditioner (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,    // raw_throttle, raw_roll, raw_pitch, raw_yaw
    input  logic [2:0]  s_tuser,    // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // throttle_out, roll_out, pitch_out, yaw_out
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [9:0]  cfg_data
);

    // Configuration registers.
    jc_pkg::cfg_t cfg_reg;

    // Input stage: the readings are scaled before they are registered, so the
    // pass after the register only subtracts, clamps and compares.
    jc_pkg::val_t  scaled_in     [jc_pkg::NUM_AXES];
    logic          s1_valid_reg;
    logic [2:0]    s1_func_reg;
    jc_pkg::val_t  s1_scaled_reg [jc_pkg::NUM_AXES];

    // Output stage.
    logic          out_valid_reg;
    jc_pkg::val_t  out_data_reg  [jc_pkg::NUM_AXES];

    jc_pkg::bias_t bias          [jc_pkg::NUM_AXES];
    jc_pkg::val_t  cond          [jc_pkg::NUM_AXES];

    logic          in_take;
    logic          out_free;
    logic          s1_sample;
    logic          s1_advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.midpoint          <= 10'd500;
            cfg_reg.center_deadzone   <= 9'd20;
            cfg_reg.throttle_deadzone <= 10'd20;
            cfg_reg.range_low         <= 10'd0;
            cfg_reg.range_high        <= 10'd1000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                jc_pkg::CFG_MIDPOINT:          cfg_reg.midpoint          <= cfg_data;
                jc_pkg::CFG_CENTER_DEADZONE:   cfg_reg.center_deadzone   <= cfg_data[8:0];
                jc_pkg::CFG_THROTTLE_DEADZONE: cfg_reg.throttle_deadzone <= cfg_data;
                jc_pkg::CFG_RANGE_LOW:         cfg_reg.range_low         <= cfg_data;
                jc_pkg::CFG_RANGE_HIGH:        cfg_reg.range_high        <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    for (genvar g = 0; g < jc_pkg::NUM_AXES; g++)
    begin : g_scale
        jc_scale u_scale (
            .raw    (s_tdata[g*jc_pkg::RAW_W +: jc_pkg::RAW_W]),
            .scaled (scaled_in[g])
        );
    end

    // Only a sample item needs room in the output stage; calibration and trim
    // items leave the input register as soon as they have updated the biases.
    assign out_free   = !out_valid_reg || m_tready;
    assign s1_sample  = (s1_func_reg == jc_pkg::FUNC_SAMPLE);
    assign s1_advance = s1_valid_reg && (!s1_sample || out_free);
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign in_take    = s_tvalid && s_tready;

    // The bias store updates on the edge where its item leaves the input
    // register, so the next item already sees the new biases.
    jc_bias u_bias (
        .clk      (clk),
        .rst_n    (rst_n),
        .update   (s1_advance),
        .func     (s1_func_reg),
        .scaled   (s1_scaled_reg),
        .midpoint (cfg_reg.midpoint),
        .bias     (bias)
    );

    jc_cond u_cond (
        .scaled (s1_scaled_reg),
        .bias   (bias),
        .cfg    (cfg_reg),
        .cond   (cond)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_advance && s1_sample)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_func_reg   <= s_tuser;
            s1_scaled_reg <= scaled_in;
        end
        if (s1_advance && s1_sample)
        begin
            out_data_reg <= cond;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg[3], out_data_reg[2], out_data_reg[1], out_data_reg[0]};

endmodule

### rtl/jc_scale.sv
// Inverts one raw 12-bit stick reading and rescales it to 0..1000.
module jc_scale (
    input  jc_pkg::raw_t raw,
    output jc_pkg::val_t scaled
);

    logic [21:0] prod;
    logic [9:0]  q_est;
    logic [12:0] rem;
    logic [9:0]  quot;

    // Dividing by 4096 undershoots the quotient by at most one; the remainder
    // against 4095 is the low part plus the estimate, so one compare fixes it.
    assign prod   = 22'(raw) * 22'(jc_pkg::SCALE_FULL);
    assign q_est  = prod[21:12];
    assign rem    = 13'(prod[11:0]) + 13'(q_est);
    assign quot   = q_est + ((rem >= 13'(jc_pkg::RAW_FULL)) ? 10'd1 : 10'd0);
    assign scaled = 10'(jc_pkg::SCALE_FULL) - quot;

endmodule

### rtl/jc_cond.sv
// Bias subtraction, range clamp and deadzones for the four axes.
module jc_cond (
    input  jc_pkg::val_t scaled [jc_pkg::NUM_AXES],
    input  jc_pkg::bias_t bias  [jc_pkg::NUM_AXES],
    input  jc_pkg::cfg_t cfg,
    output jc_pkg::val_t cond   [jc_pkg::NUM_AXES]
);

    logic signed [11:0] diff    [jc_pkg::NUM_AXES];
    jc_pkg::val_t       clamped [jc_pkg::NUM_AXES];
    logic signed [10:0] offset  [jc_pkg::NUM_AXES];
    logic signed [10:0] mag     [jc_pkg::NUM_AXES];

    always_comb
    begin
        for (int i = 0; i < jc_pkg::NUM_AXES; i++)
        begin
            diff[i] = $signed({2'b00, scaled[i]}) - 12'(bias[i]);

            // Low bound is tested first: with an inverted range, values below it still go to range_low.
            if (diff[i] < $signed({2'b00, cfg.range_low}))
            begin
                clamped[i] = cfg.range_low;
            end
            else if (diff[i] > $signed({2'b00, cfg.range_high}))
            begin
                clamped[i] = cfg.range_high;
            end
            else
            begin
                clamped[i] = diff[i][9:0];
            end

            offset[i] = $signed({1'b0, clamped[i]}) - $signed({1'b0, cfg.midpoint});
            mag[i]    = (offset[i] < 0) ? -offset[i] : offset[i];

            if (i == jc_pkg::AXIS_THROTTLE)
            begin
                cond[i] = (clamped[i] <= cfg.throttle_deadzone) ? '0 : clamped[i];
            end
            else
            begin
                cond[i] = (11'(mag[i]) <= {2'b00, cfg.center_deadzone}) ?
                          cfg.midpoint : clamped[i];
            end
        end
    end

endmodule

### rtl/jc_bias.sv
// Per-axis bias store with calibration averaging and trim steps.
module jc_bias (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          update,
    input  logic [2:0]    func,
    input  jc_pkg::val_t  scaled [jc_pkg::NUM_AXES],
    input  logic [9:0]    midpoint,
    output jc_pkg::bias_t bias   [jc_pkg::NUM_AXES]
);

    localparam jc_pkg::sum_t CAL_DIV = jc_pkg::SUM_W'(jc_pkg::BIAS_SAMPLES);

    jc_pkg::bias_t           bias_reg  [jc_pkg::NUM_AXES];
    jc_pkg::bias_t           bias_next [jc_pkg::NUM_AXES];
    jc_pkg::sum_t            sum_reg   [jc_pkg::NUM_AXES];
    jc_pkg::sum_t            sum_next  [jc_pkg::NUM_AXES];
    jc_pkg::sum_t            sum_inc   [jc_pkg::NUM_AXES];
    jc_pkg::sum_t            cal_quot  [jc_pkg::NUM_AXES];
    logic signed [11:0]      cal_add   [jc_pkg::NUM_AXES];
    logic [jc_pkg::CNT_W-1:0] count_reg;
    logic [jc_pkg::CNT_W-1:0] count_next;
    logic [jc_pkg::CNT_W-1:0] count_inc;
    logic                    cal_done;

    // Step a bias by one trim unit and saturate it to the bias limit.
    function automatic jc_pkg::bias_t trim_bias(jc_pkg::bias_t b, logic up);
        logic signed [11:0] t;
        begin
            t = up ? (12'(b) + 12'(jc_pkg::TRIM_STEP)) : (12'(b) - 12'(jc_pkg::TRIM_STEP));
            if (t > 12'(jc_pkg::BIAS_LIMIT))
            begin
                t = 12'(jc_pkg::BIAS_LIMIT);
            end
            if (t < 12'(-jc_pkg::BIAS_LIMIT))
            begin
                t = 12'(-jc_pkg::BIAS_LIMIT);
            end
            return t[10:0];
        end
    endfunction

    always_comb
    begin
        count_inc = count_reg + 1'b1;
        cal_done  = (count_inc >= jc_pkg::CNT_W'(jc_pkg::BIAS_SAMPLES));
        for (int i = 0; i < jc_pkg::NUM_AXES; i++)
        begin
            // Throttle is averaged against zero, the others against midpoint.
            if (i == jc_pkg::AXIS_THROTTLE)
            begin
                cal_add[i] = $signed({2'b00, scaled[i]});
            end
            else
            begin
                cal_add[i] = $signed({2'b00, scaled[i]}) - $signed({2'b00, midpoint});
            end
            sum_inc[i]  = sum_reg[i] + jc_pkg::SUM_W'(cal_add[i]);
            cal_quot[i] = sum_inc[i] / CAL_DIV;  // truncates toward zero
        end

        bias_next  = bias_reg;
        sum_next   = sum_reg;
        count_next = count_reg;

        if (update)
        begin
            unique case (func)
                jc_pkg::FUNC_CAL:
                begin
                    if (cal_done)
                    begin
                        for (int i = 0; i < jc_pkg::NUM_AXES; i++)
                        begin
                            bias_next[i] = cal_quot[i][jc_pkg::BIAS_W-1:0];
                            sum_next[i]  = '0;
                        end
                        count_next = '0;
                    end
                    else
                    begin
                        sum_next   = sum_inc;
                        count_next = count_inc;
                    end
                end
                jc_pkg::FUNC_ROLL_UP:
                    bias_next[jc_pkg::AXIS_ROLL] = trim_bias(bias_reg[jc_pkg::AXIS_ROLL], 1'b1);
                jc_pkg::FUNC_ROLL_DN:
                    bias_next[jc_pkg::AXIS_ROLL] = trim_bias(bias_reg[jc_pkg::AXIS_ROLL], 1'b0);
                jc_pkg::FUNC_PITCH_UP:
                    bias_next[jc_pkg::AXIS_PITCH] = trim_bias(bias_reg[jc_pkg::AXIS_PITCH], 1'b1);
                jc_pkg::FUNC_PITCH_DN:
                    bias_next[jc_pkg::AXIS_PITCH] = trim_bias(bias_reg[jc_pkg::AXIS_PITCH], 1'b0);
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < jc_pkg::NUM_AXES; i++)
            begin
                bias_reg[i] <= '0;
                sum_reg[i]  <= '0;
            end
            count_reg <= '0;
        end
        else
        begin
            bias_reg  <= bias_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

    assign bias = bias_reg;

endmodule

### rtl/jc_checker.sv
// Port-level checks for the joystick conditioner and the bind that attaches them.
module jc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // A stalled output item stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output item dropped while stalled");

    // A stalled output item keeps its values.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output item changed while stalled");

    // The input side only backs up behind a stalled output.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a stalled output");

    // An output item that starts from an empty output stage comes from a sample
    // item accepted on s_*, which passed through the input register into the output register.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |->
            $past(s_tvalid && s_tready && (s_tuser == jc_pkg::FUNC_SAMPLE), 2))
        else $error("output item without a matching sample item");

endmodule

bind joystick_conditioner jc_checker u_checker (.*);

### tb/sv/tb_top.sv
// Self-checking stream testbench for the joystick conditioner.
`timescale 1ns / 100ps

module tb_top;
    import jc_pkg::*;

    // A sample item passes the input register and then the output register.
    localparam int PIPE_DEPTH  = 2;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_PRINTS  = 40;

    // Function codes that the block must ignore.
    localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

    // Register indexes with no register behind them.
    localparam logic [2:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CFG_SPARE_LAST  = 3'd7;

    // Element 0 is throttle, then roll, pitch and yaw, as packed on the stream.
    typedef raw_t [NUM_AXES-1:0] raw_set_t;
    typedef val_t [NUM_AXES-1:0] stick_vals_t;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;    // raw_throttle, raw_roll, raw_pitch, raw_yaw
    logic [2:0]  s_tuser   = '0;    // func
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;           // throttle_out, roll_out, pitch_out, yaw_out
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [9:0]  cfg_data  = '0;

    // Our own copy of the block's registers, biases and calibration state.
    cfg_t settings = '{midpoint: 10'd500, center_deadzone: 9'd20, throttle_deadzone: 10'd20,
                       range_low: 10'd0, range_high: 10'd1000};
    int axis_offset [NUM_AXES] = '{default: 0};
    int cal_acc [NUM_AXES]     = '{default: 0};
    int cal_taken              = 0;

    // Conditioned values still owed by the block, oldest first.
    stick_vals_t pending_outputs [$];

    string axis_label [NUM_AXES] = '{"throttle", "roll", "pitch", "yaw"};

    int errors          = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int reg_writes      = 0;
    int bias_updates    = 0;

    // Flow control knobs shared by the tests, the sender and the receiver.
    bit       sender_gaps = 1'b0;
    int       burst_left  = 1;
    rx_mode_t rx_mode     = RX_ALWAYS;
    int       rx_tick     = 0;
    int       hold_left   = 0;

    joystick_conditioner dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs or drops items.
    initial
    begin
        #3_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= MAX_PRINTS)
        begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
    endtask

    // Invert and rescale a raw reading to 0..1000, truncating.
    function automatic int scaled(raw_t x);
        return SCALE_FULL - (int'(x) * SCALE_FULL) / RAW_FULL;
    endfunction

    // Smallest raw reading whose scaled value equals the target.
    function automatic raw_t raw_for(int target);
        if (target >= SCALE_FULL)
        begin
            return '0;
        end
        if (target <= 0)
        begin
            return raw_t'(RAW_FULL);
        end
        return raw_t'(((SCALE_FULL - target) * RAW_FULL + SCALE_FULL - 1) / SCALE_FULL);
    endfunction

    // Raw readings are drawn mostly near the edges that matter under the
    // current settings and biases: the snap window, the throttle cutoff and
    // the clamp limits. The rest are fully random or at the rails.
    function automatic raw_t rand_raw(int axis);
        int target;
        case ($urandom_range(0, 7))
            0, 1:    return raw_t'($urandom_range(0, RAW_FULL));
            2:       return ($urandom_range(0, 1) != 0) ? raw_t'(0) : raw_t'(RAW_FULL);
            3:       target = int'(settings.midpoint) - int'(settings.center_deadzone);
            4:       target = int'(settings.midpoint) + int'(settings.center_deadzone);
            5:       target = int'(settings.throttle_deadzone);
            6:       target = int'(settings.range_low);
            default: target = int'(settings.range_high);
        endcase
        target = target + axis_offset[axis] + int'($urandom_range(0, 4)) - 2;
        return raw_for(target);
    endfunction

    function automatic raw_set_t random_raws();
        raw_set_t raws;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            raws[i] = rand_raw(i);
        end
        return raws;
    endfunction

    function automatic raw_set_t flat_raws(raw_t x);
        return {x, x, x, x};
    endfunction

    // Samples dominate, calibration is frequent enough to finish runs
    // within the random phases, and a few ignored codes are mixed in.
    function automatic logic [2:0] pick_func();
        int dice;
        dice = $urandom_range(0, 99);
        if (dice < 45)
        begin
            return FUNC_SAMPLE;
        end
        if (dice < 72)
        begin
            return FUNC_CAL;
        end
        if (dice < 94)
        begin
            return 3'($urandom_range(FUNC_ROLL_UP, FUNC_PITCH_UP));
        end
        return ($urandom_range(0, 1) != 0) ? FUNC_SPARE_6 : FUNC_SPARE_7;
    endfunction

    // Trims saturate at the bias limit in both directions.
    function automatic void nudge_offset(int axis, int delta);
        int b;
        b = axis_offset[axis] + delta;
        if (b > BIAS_LIMIT)
        begin
            b = BIAS_LIMIT;
        end
        if (b < -BIAS_LIMIT)
        begin
            b = -BIAS_LIMIT;
        end
        axis_offset[axis] = b;
    endfunction

    // Applies one accepted item to our state and queues the output it owes.
    task automatic predict_item(logic [2:0] f, raw_set_t raws);
        int s [NUM_AXES];
        int mid_gap;
        stick_vals_t vals;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            s[i] = scaled(raws[i]);
        end
        case (f)
            FUNC_SAMPLE:
            begin
                // The clamp tests the low limit first, so an inverted range
                // still lifts values below range_low up to range_low.
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    s[i] = s[i] - axis_offset[i];
                    if (s[i] < int'(settings.range_low))
                    begin
                        s[i] = int'(settings.range_low);
                    end
                    else if (s[i] > int'(settings.range_high))
                    begin
                        s[i] = int'(settings.range_high);
                    end
                end
                for (int i = AXIS_ROLL; i < NUM_AXES; i++)
                begin
                    mid_gap = s[i] - int'(settings.midpoint);
                    if (mid_gap < 0)
                    begin
                        mid_gap = -mid_gap;
                    end
                    if (mid_gap <= int'(settings.center_deadzone))
                    begin
                        s[i] = int'(settings.midpoint);
                    end
                end
                if (s[AXIS_THROTTLE] <= int'(settings.throttle_deadzone))
                begin
                    s[AXIS_THROTTLE] = 0;
                end
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    vals[i] = s[i][VAL_W-1:0];
                end
                pending_outputs.push_back(vals);
            end
            FUNC_CAL:
            begin
                // Throttle is summed against zero, the other sticks against
                // the midpoint in force when the item arrives.
                cal_acc[AXIS_THROTTLE] += s[AXIS_THROTTLE];
                for (int i = AXIS_ROLL; i < NUM_AXES; i++)
                begin
                    cal_acc[i] += s[i] - int'(settings.midpoint);
                end
                cal_taken = (cal_taken + 1) % 256;
                if (cal_taken >= BIAS_SAMPLES)
                begin
                    // Integer division truncates toward zero, as the block does.
                    for (int i = 0; i < NUM_AXES; i++)
                    begin
                        axis_offset[i] = cal_acc[i] / BIAS_SAMPLES;
                        cal_acc[i] = 0;
                    end
                    cal_taken = 0;
                    bias_updates++;
                end
            end
            FUNC_ROLL_UP:  nudge_offset(AXIS_ROLL, TRIM_STEP);
            FUNC_PITCH_DN: nudge_offset(AXIS_PITCH, -TRIM_STEP);
            FUNC_ROLL_DN:  nudge_offset(AXIS_ROLL, -TRIM_STEP);
            FUNC_PITCH_UP: nudge_offset(AXIS_PITCH, TRIM_STEP);
            default:
            begin
            end
        endcase
    endtask

    // Offers one item and returns right after the edge that took it. The
    // valid stays high into the next item unless a gap ends the burst.
    task automatic send_item(logic [2:0] f, raw_set_t raws);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= raws;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        predict_item(f, raws);
        items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = sender_gaps ? $urandom_range(0, 6) : 0;
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Waits until every owed output is back, then lets any calibration or
    // trim item still inside the block settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_outputs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [9:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            CFG_MIDPOINT:          settings.midpoint          = value;
            CFG_CENTER_DEADZONE:   settings.center_deadzone   = value[8:0];
            CFG_THROTTLE_DEADZONE: settings.throttle_deadzone = value;
            CFG_RANGE_LOW:         settings.range_low         = value;
            CFG_RANGE_HIGH:        settings.range_high        = value;
            default:
            begin
            end
        endcase
        reg_writes++;
    endtask

    // Rewrites every register, plus one index that has no register, while
    // the block is idle.
    task automatic apply_settings(int mid, int cdz, int tdz, int lo, int hi);
        wait_idle();
        write_reg(CFG_MIDPOINT, 10'(mid));
        write_reg(CFG_CENTER_DEADZONE, 10'(cdz));
        write_reg(CFG_THROTTLE_DEADZONE, 10'(tdz));
        write_reg(CFG_RANGE_LOW, 10'(lo));
        write_reg(CFG_RANGE_HIGH, 10'(hi));
        write_reg(3'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
                  10'($urandom_range(0, 1023)));
        cfg_valid <= 1'b0;
    endtask

    task automatic check_output(logic [39:0] data);
        stick_vals_t got;
        stick_vals_t want;
        got = data;
        if (pending_outputs.size() == 0)
        begin
            report_mismatch($sformatf("output %h arrived with nothing expected", data));
            return;
        end
        want = pending_outputs.pop_front();
        results_checked++;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            if (got[i] !== want[i])
            begin
                report_mismatch($sformatf("output %0d %s: got %0d, expected %0d",
                                          results_checked, axis_label[i], got[i], want[i]));
            end
        end
    endtask

    // Receiver: checks each output handshake, then picks the next ready
    // value. A pending hold keeps ready low until it has counted down.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            check_output(m_tdata);
        end
        rx_tick++;
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_ALWAYS:  m_tready <= 1'b1;
                RX_RANDOM:  m_tready <= ($urandom_range(0, 3) != 0);
                RX_PATTERN: m_tready <= ((rx_tick % 7) < 4);
                default:    m_tready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    // Rails, the default snap window and throttle cutoff edges, every trim,
    // one calibration item and the two ignored codes.
    task automatic test_directed_cases();
        sender_gaps = 1'b0;
        rx_mode     = RX_ALWAYS;
        send_item(FUNC_SAMPLE, flat_raws(raw_t'(0)));
        send_item(FUNC_SAMPLE, flat_raws(raw_t'(RAW_FULL)));
        send_item(FUNC_SAMPLE, flat_raws(raw_for(500)));
        send_item(FUNC_SAMPLE, {raw_t'(RAW_FULL), raw_t'(0), raw_t'(RAW_FULL), raw_t'(0)});
        // Fields run {yaw, pitch, roll, throttle}: just inside and just
        // outside the snap window, and both sides of the throttle cutoff.
        send_item(FUNC_SAMPLE, {raw_for(480), raw_for(520), raw_for(479), raw_for(20)});
        send_item(FUNC_SAMPLE, {raw_for(521), raw_for(479), raw_for(480), raw_for(21)});
        send_item(FUNC_SPARE_6, random_raws());
        send_item(FUNC_SPARE_7, random_raws());
        send_item(FUNC_SAMPLE, flat_raws(raw_for(525)));
        send_item(FUNC_ROLL_UP, random_raws());
        send_item(FUNC_SAMPLE, flat_raws(raw_for(525)));
        send_item(FUNC_PITCH_DN, random_raws());
        send_item(FUNC_SAMPLE, flat_raws(raw_for(475)));
        send_item(FUNC_ROLL_DN, random_raws());
        send_item(FUNC_PITCH_UP, random_raws());
        send_item(FUNC_CAL, random_raws());
        send_item(FUNC_SAMPLE, flat_raws(raw_for(540)));
    endtask

    // Calibration at the extremes leaves biases at +1000 and at -1023,
    // the latter beyond the trim limit, then trims pull them back in.
    task automatic test_calibration_limits();
        sender_gaps = 1'b1;
        rx_mode     = RX_RANDOM;
        apply_settings(0, 20, 20, 0, 1000);
        // Finish any run left open so the next ones start from zero.
        repeat ((BIAS_SAMPLES - cal_taken) % BIAS_SAMPLES) send_item(FUNC_CAL, random_raws());
        repeat (BIAS_SAMPLES) send_item(FUNC_CAL, flat_raws(raw_t'(0)));
        send_item(FUNC_SAMPLE, random_raws());
        send_item(FUNC_ROLL_UP, random_raws());
        send_item(FUNC_PITCH_UP, random_raws());
        send_item(FUNC_ROLL_DN, random_raws());
        send_item(FUNC_SAMPLE, flat_raws(raw_t'(0)));
        send_item(FUNC_ROLL_UP, random_raws());
        send_item(FUNC_ROLL_UP, random_raws());
        send_item(FUNC_SAMPLE, flat_raws(raw_t'(0)));
        apply_settings(1023, 20, 20, 0, 1000);
        repeat (BIAS_SAMPLES) send_item(FUNC_CAL, flat_raws(raw_t'(RAW_FULL)));
        send_item(FUNC_SAMPLE, flat_raws(raw_t'(0)));
        send_item(FUNC_SAMPLE, random_raws());
        send_item(FUNC_PITCH_UP, random_raws());
        send_item(FUNC_SAMPLE, flat_raws(raw_t'(0)));
        send_item(FUNC_PITCH_DN, random_raws());
        send_item(FUNC_ROLL_DN, random_raws());
        send_item(FUNC_ROLL_DN, random_raws());
        send_item(FUNC_SAMPLE, flat_raws(raw_t'(0)));
        // An ordinary run with samples woven between the calibration items.
        apply_settings(500, 20, 20, 0, 1000);
        for (int k = 0; k < 24; k++)
        begin
            send_item((k % 3 == 2) ? FUNC_SAMPLE : FUNC_CAL, random_raws());
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering, so the block fills and stalls its input.
    task automatic test_output_backpressure();
        sender_gaps = 1'b0;
        rx_mode     = RX_ALWAYS;
        hold_left   = HOLD_CYCLES;
        repeat (60) send_item(pick_func(), random_raws());
    endtask

    // Random traffic under several register settings: reset values, zero
    // and full-scale extremes, values above the documented ranges, an
    // inverted clamp range and a random mix.
    task automatic test_random_phases();
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: apply_settings(500, 20, 20, 0, 1000);
                1: apply_settings(0, 0, 0, 0, 1000);
                2: apply_settings(1000, 500, 1000, 0, 1000);
                3: apply_settings(1023, 1023, 1023, 1023, 1023);
                4: apply_settings(300, 40, 50, 800, 200);
                default: apply_settings($urandom_range(0, 1023), $urandom_range(0, 1023),
                                        $urandom_range(0, 1023), $urandom_range(0, 500),
                                        $urandom_range(500, 1000));
            endcase
            // The first phase runs with no idling on either side.
            sender_gaps = (p != 0);
            rx_mode     = (p == 0) ? RX_ALWAYS : rx_mode_t'(p % 4);
            repeat (110) send_item(pick_func(), random_raws());
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_calibration_limits();
        test_output_backpressure();
        test_random_phases();

        // Drain with a bound, then keep watching for strays.
        s_tvalid <= 1'b0;
        rx_mode = RX_RANDOM;
        for (int n = 0; n < 5000 && pending_outputs.size() != 0; n++)
        begin
            @(posedge clk);
        end
        repeat (PIPE_DEPTH + 4) @(posedge clk);
        if (pending_outputs.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected outputs never arrived",
                                      pending_outputs.size()));
        end

        $display("Run covered %0d items, %0d outputs checked, %0d register writes, %0d bias updates.",
                 items_sent, results_checked, reg_writes, bias_updates);
        $display("Included rail and edge readings, trim limits, inverted range, %0d-cycle stall.",
                 HOLD_CYCLES);
        if (errors == 0)
        begin
            $display("tb_top OK");
        end
        else
        begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/jc_pkg.sv
rtl/jc_scale.sv
rtl/jc_cond.sv
rtl/jc_bias.sv
rtl/joystick_conditioner.sv
rtl/jc_checker.sv
tb/sv/tb_top.sv
